[design/kwsc_pkg.sv]
package kwsc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int IDX_W = $clog2(ALPHABET_SIZE);
    localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);

    localparam logic [7:0] LETTER_A = 8'd65;
    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_ADD = 3'd1;
    localparam logic [2:0] CMD_FINISH = 3'd2;
    localparam logic [2:0] CMD_ENCRYPT = 3'd3;
    localparam logic [2:0] CMD_DECRYPT = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_LETTER = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;
    localparam logic [1:0] ST_NOT_UPPER = 2'd3;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] letter;
        logic [IDX_W-1:0] pos;
    } tbl_wr_t;

    typedef struct packed {
        logic             en;
        logic             inverse;
        logic [IDX_W-1:0] addr;
    } tbl_rd_t;

endpackage

[design/kwsc_tables.sv]
module kwsc_tables #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    // single write port, registered read
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/keyword_substitution_cipher_core.sv]
// Channel  Direction  tdata           tuser
// s_       in         symbol[7:0]     command[2:0]
// m_       out        symbol_out[7:0] status[1:0]
//
// One word at a time; s_tready is high only while the core is idle.
// Start, add, unused commands and errors: result valid the cycle after accept.
// Good encrypt/decrypt: S_READ (registered table read), then S_OUT.
// Good finish: S_WALK over the alphabet, one letter per cycle through the
// shared placement unit. A held result blocks the next word until taken.
// aresetn (sync, active low) clears key state; tables are written by add letter and finish.
module keyword_substitution_cipher_core
    import kwsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // symbol[7:0]
    input  logic [2:0] s_tuser,   // command[2:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // symbol_out[7:0]
    output logic [1:0] m_tuser    // status[1:0]
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [ALPHABET_SIZE-1:0] used_reg, used_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic invalid_reg, invalid_next;
    logic ready_reg, ready_next;
    logic [IDX_W-1:0] walk_reg, walk_next;
    logic [7:0] sym_out_reg, sym_out_next;
    logic [1:0] status_reg, status_next;
    logic inv_sel_reg, inv_sel_next;

    logic accept;
    logic [7:0] folded;
    logic key_alpha, data_alpha;
    logic [IDX_W-1:0] key_idx, data_idx;
    logic [IDX_W-1:0] place_idx;
    logic place_ok;
    logic [IDX_W-1:0] fwd_rd_data;
    logic [IDX_W-1:0] inv_rd_data;
    tbl_wr_t wr;
    tbl_rd_t rd;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // key letters fold to upper case; lookups do not
    assign folded = (s_tdata >= LOWER_A && s_tdata <= LOWER_Z) ?
                    s_tdata - CASE_OFFSET : s_tdata;
    assign key_alpha = (folded >= LETTER_A) &&
                       ({1'b0, folded} < 9'(LETTER_A) + 9'(ALPHABET_SIZE));
    assign data_alpha = (s_tdata >= LETTER_A) &&
                        ({1'b0, s_tdata} < 9'(LETTER_A) + 9'(ALPHABET_SIZE));
    assign key_idx = IDX_W'(folded - LETTER_A);
    assign data_idx = IDX_W'(s_tdata - LETTER_A);

    // shared placement unit: key letters when idle, alphabet walk on finish
    assign place_idx = (state_reg == S_WALK) ? walk_reg : key_idx;
    assign place_ok = (fill_reg < CNT_W'(ALPHABET_SIZE)) && !used_reg[place_idx];

    always_comb begin
        state_next = state_reg;
        used_next = used_reg;
        fill_next = fill_reg;
        invalid_next = invalid_reg;
        ready_next = ready_reg;
        walk_next = walk_reg;
        sym_out_next = sym_out_reg;
        status_next = status_reg;
        inv_sel_next = inv_sel_reg;
        wr = '{en: 1'b0, letter: place_idx, pos: fill_reg[IDX_W-1:0]};
        rd = '{en: 1'b0, inverse: (s_tuser == CMD_DECRYPT), addr: data_idx};

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    sym_out_next = s_tdata;
                    status_next = ST_OK;
                    state_next = S_OUT;
                    case (s_tuser)
                        CMD_START: begin
                            used_next = '0;
                            fill_next = '0;
                            invalid_next = 1'b0;
                            ready_next = 1'b0;
                        end
                        CMD_ADD: begin
                            if (!key_alpha) begin
                                status_next = ST_BAD_LETTER;
                                if (!ready_reg) invalid_next = 1'b1;
                            end else if (!ready_reg && place_ok) begin
                                wr.en = 1'b1;
                                used_next[place_idx] = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        CMD_FINISH: begin
                            if (invalid_reg) begin
                                status_next = ST_NOT_READY;
                            end else begin
                                walk_next = '0;
                                state_next = S_WALK;
                            end
                        end
                        CMD_ENCRYPT, CMD_DECRYPT: begin
                            if (!ready_reg) begin
                                status_next = ST_NOT_READY;
                            end else if (!data_alpha) begin
                                status_next = ST_NOT_UPPER;
                            end else begin
                                rd.en = 1'b1;
                                inv_sel_next = rd.inverse;
                                state_next = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (place_ok) begin
                    wr.en = 1'b1;
                    used_next[place_idx] = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                walk_next = walk_reg + 1'b1;
                if (walk_reg == IDX_W'(ALPHABET_SIZE - 1)) begin
                    ready_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_READ: begin
                sym_out_next = LETTER_A + 8'(inv_sel_reg ? inv_rd_data : fwd_rd_data);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            fill_reg <= '0;
            invalid_reg <= 1'b0;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg <= used_next;
            fill_reg <= fill_next;
            invalid_reg <= invalid_next;
            ready_reg <= ready_next;
        end
        walk_reg <= walk_next;
        sym_out_reg <= sym_out_next;
        status_reg <= status_next;
        inv_sel_reg <= inv_sel_next;
    end

    // forward: position -> letter
    kwsc_tables #(
        .WIDTH (IDX_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_fwd_table (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.pos),
        .wr_data (wr.letter),
        .rd_en   (rd.en),
        .rd_addr (rd.addr),
        .rd_data (fwd_rd_data)
    );

    // inverse: letter -> position
    kwsc_tables #(
        .WIDTH (IDX_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_inv_table (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.letter),
        .wr_data (wr.pos),
        .rd_en   (rd.en),
        .rd_addr (rd.addr),
        .rd_data (inv_rd_data)
    );

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = sym_out_reg;
    assign m_tuser = status_reg;

endmodule

[test/tb.sv]
module tb;
    import kwsc_pkg::*;

    // Commands the core ignores: echoed back with an ok status.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST = 3'd7;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = ALPHABET_SIZE + 12;
    localparam int MAX_PRINTED = 20;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] sym;
        logic [7:0] symbol_out;
        logic [1:0] status;
    } cipher_result_t;

    // Keeps its own copy of the key state and predicts one result per word.
    class cipher_scoreboard;
        logic [IDX_W-1:0]         fwd_map [ALPHABET_SIZE];
        logic [IDX_W-1:0]         inv_map [ALPHABET_SIZE];
        logic [ALPHABET_SIZE-1:0] used_mask;
        logic [CNT_W-1:0]         fill_pos;
        bit                       key_invalid;
        bit                       key_ready;
        cipher_result_t           pending_q[$];
        int unsigned              fail_count;

        function new();
            clear_key();
            fail_count = 0;
        endfunction

        function void clear_key();
            used_mask = '0;
            fill_pos = '0;
            key_invalid = 1'b0;
            key_ready = 1'b0;
        endfunction

        function int letter_index(logic [7:0] c);
            if (c >= LETTER_A && c < LETTER_A + ALPHABET_SIZE) begin
                return int'(c) - int'(LETTER_A);
            end
            return -1;
        endfunction

        // Append a letter to the key unless it is already there or the table is full.
        function void place(int idx);
            if (fill_pos >= ALPHABET_SIZE || used_mask[idx]) begin
                return;
            end
            fwd_map[fill_pos] = idx[IDX_W-1:0];
            inv_map[idx] = fill_pos[IDX_W-1:0];
            used_mask[idx] = 1'b1;
            fill_pos++;
        endfunction

        function void note_word(logic [2:0] cmd, logic [7:0] sym);
            cipher_result_t r;
            logic [7:0]     folded;
            int             idx;
            int             i;
            r.cmd = cmd;
            r.sym = sym;
            r.symbol_out = sym;
            r.status = ST_OK;
            case (cmd)
                CMD_START: begin
                    clear_key();
                end
                CMD_ADD: begin
                    folded = (sym >= LOWER_A && sym <= LOWER_Z) ? sym - CASE_OFFSET : sym;
                    idx = letter_index(folded);
                    if (idx < 0) begin
                        r.status = ST_BAD_LETTER;
                        // once the key is done, a bad letter is only reported
                        if (!key_ready) key_invalid = 1'b1;
                    end else if (!key_ready) begin
                        place(idx);
                    end
                end
                CMD_FINISH: begin
                    if (key_invalid) begin
                        r.status = ST_NOT_READY;
                    end else begin
                        for (i = 0; i < ALPHABET_SIZE; i++) place(i);
                        key_ready = 1'b1;
                    end
                end
                CMD_ENCRYPT, CMD_DECRYPT: begin
                    idx = letter_index(sym);
                    if (!key_ready) begin
                        r.status = ST_NOT_READY;
                    end else if (idx < 0) begin
                        r.status = ST_NOT_UPPER;
                    end else if (cmd == CMD_ENCRYPT) begin
                        r.symbol_out = LETTER_A + fwd_map[idx];
                    end else begin
                        r.symbol_out = LETTER_A + inv_map[idx];
                    end
                end
                default: ;
            endcase
            pending_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (fail_count < MAX_PRINTED) $display("mismatch: %s", msg);
            fail_count++;
        endtask

        task check_word(logic [7:0] symbol_out, logic [1:0] status);
            cipher_result_t want;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word symbol=%h status=%0d",
                                          symbol_out, status));
                return;
            end
            want = pending_q.pop_front();
            if (symbol_out !== want.symbol_out) begin
                report_mismatch($sformatf("cmd=%0d sym=%h: symbol_out %h, wanted %h",
                                          want.cmd, want.sym, symbol_out, want.symbol_out));
            end
            if (status !== want.status) begin
                report_mismatch($sformatf("cmd=%0d sym=%h: status %0d, wanted %0d",
                                          want.cmd, want.sym, status, want.status));
            end
        endtask
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [2:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    cipher_scoreboard sb = new();
    int src_idle_pct;
    int sink_idle_pct;
    int word_count;
    int idle_cycles;

    keyword_substitution_cipher_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] rand_upper();
        return LETTER_A + 8'($urandom_range(ALPHABET_SIZE - 1));
    endfunction

    function automatic logic [2:0] rand_lookup();
        return $urandom_range(1) ? CMD_ENCRYPT : CMD_DECRYPT;
    endfunction

    // Drive one word, idling first at the sender's current rate.
    task automatic send_word(input logic [2:0] cmd, input logic [7:0] sym);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= sym;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(cmd, sym);
        if (cmd <= CMD_DECRYPT) word_count++;
    endtask

    // One key life: start, a keyword of mixed case with repeats and the odd bad
    // byte, finish, then a run of lookups with a little noise mixed in.
    task automatic run_key_session();
        int         n_key;
        int         n_look;
        int         pick;
        logic [7:0] ch;
        send_word(CMD_START, rand_byte());
        n_key = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
        repeat (n_key) begin
            if ($urandom_range(49) == 0) begin
                ch = rand_byte();
            end else begin
                ch = rand_upper() + ($urandom_range(1) ? CASE_OFFSET : '0);
            end
            send_word(CMD_ADD, ch);
            if ($urandom_range(39) == 0) send_word(rand_lookup(), rand_upper());
        end
        send_word(CMD_FINISH, rand_byte());
        n_look = $urandom_range(24, 4);
        repeat (n_look) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_word(rand_lookup(), rand_upper());
            end else if (pick < 90) begin
                send_word(rand_lookup(), rand_byte());
            end else if (pick < 94) begin
                send_word(CMD_ADD, rand_byte());
            end else if (pick < 97) begin
                send_word(CMD_FINISH, rand_byte());
            end else begin
                send_word(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), rand_byte());
            end
        end
    endtask

    // Result side: check what is taken, then pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Ends the run when neither side moves a word for too long.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        m_tready <= 1'b0;
        word_count = 0;
        src_idle_pct = 36;
        sink_idle_pct = 77;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // lookups before any key, and an ignored command
        send_word(CMD_ENCRYPT, "A");
        send_word(CMD_DECRYPT, 8'hFF);
        send_word(CMD_SPARE_FIRST, 8'h00);
        // keyword with folding and a repeat
        send_word(CMD_START, "K");
        send_word(CMD_ADD, "k");
        send_word(CMD_ADD, "E");
        send_word(CMD_ADD, "K");
        send_word(CMD_ADD, "Z");
        send_word(CMD_FINISH, 8'h00);
        send_word(CMD_ENCRYPT, "A");
        send_word(CMD_ENCRYPT, "Z");
        send_word(CMD_DECRYPT, "K");
        // not upper case: lower case, newline, just past Z
        send_word(CMD_ENCRYPT, "a");
        send_word(CMD_DECRYPT, "\n");
        send_word(CMD_ENCRYPT, "[");
        // bad letter after finish, then finishing twice
        send_word(CMD_ADD, "3");
        send_word(CMD_FINISH, "x");
        // invalid key: byte just past lower-case z
        send_word(CMD_START, 8'hFF);
        send_word(CMD_ADD, "{");
        send_word(CMD_FINISH, 8'h00);
        send_word(CMD_ENCRYPT, "M");
        // empty key gives the identity map
        send_word(CMD_START, 8'h00);
        send_word(CMD_FINISH, 8'h00);
        send_word(CMD_ENCRYPT, "M");
        send_word(CMD_DECRYPT, "Z");

        while (word_count < 250) run_key_session();
        src_idle_pct = 77;
        sink_idle_pct = 36;
        while (word_count < 500) run_key_session();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        while (word_count < 750) run_key_session();
        s_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
